/* src/triple_tap_confirm_sequencer_top_defines.svh */
// Assertion macros shared by the triple-tap confirmation sequencer.
`ifndef TRIPLE_TAP_CONFIRM_SEQUENCER_TOP_DEFINES_SVH
`define TRIPLE_TAP_CONFIRM_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttc assertion failed");

`endif

/* src/ttc_pkg.sv */
// Types, codes and defaults shared by the triple-tap confirmation sequencer.
package ttc_pkg;

  localparam int TIME_WIDTH_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [1:0] LED_NORMAL = 2'd0;
  localparam logic [1:0] LED_AMBER  = 2'd1;
  localparam logic [1:0] LED_DARK   = 2'd2;
  localparam logic [1:0] LED_RED    = 2'd3;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_TOUCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_ZONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_NEEDED = 3'd4;

  localparam logic [3:0]  RST_TAP_ZONE    = 4'd0;
  localparam logic [15:0] RST_TAP_WINDOW  = 16'd3000;
  localparam logic [15:0] RST_CONFIRM_TO  = 16'd5000;
  localparam logic [15:0] RST_BLINK_PER   = 16'd300;
  localparam logic [3:0]  RST_TAPS_NEEDED = 4'd3;

  typedef struct packed {
    logic       func;
    logic [3:0] zone;
  } in_t;

  typedef struct packed {
    logic [1:0] led_mode;
    logic       confirming;
    logic       reset_request;
    logic       cancelled;
  } out_t;

  typedef struct packed {
    logic [3:0]  touch_zone;
    logic [15:0] tap_window_ms;
    logic [15:0] countdown_ms;
    logic [15:0] flash_ms;
    logic [3:0]  taps_needed;
  } cfg_t;

endpackage

/* src/ttc_cfg_regs.sv */
// Configuration register file of the triple-tap confirmation sequencer.
module ttc_cfg_regs
  import ttc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_TAP_ZONE:    cfg_nxt.touch_zone    = wr_data[3:0];
        CFG_TAP_WINDOW:  cfg_nxt.tap_window_ms = wr_data;
        CFG_CONFIRM_TO:  cfg_nxt.countdown_ms  = wr_data;
        CFG_BLINK_PER:   cfg_nxt.flash_ms      = wr_data;
        CFG_TAPS_NEEDED: cfg_nxt.taps_needed   = wr_data[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_zone    <= RST_TAP_ZONE;
      cfg_r.tap_window_ms <= RST_TAP_WINDOW;
      cfg_r.countdown_ms  <= RST_CONFIRM_TO;
      cfg_r.flash_ms      <= RST_BLINK_PER;
      cfg_r.taps_needed   <= RST_TAPS_NEEDED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/ttc_core.sv */
// Tap counting, countdown and blink state with the per-word update logic.
module ttc_core
  import ttc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  localparam int CMP_W = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;

  logic [3:0]            tap_cnt_r, tap_cnt_nxt;
  logic [TIME_WIDTH-1:0] tap_el_r, tap_el_nxt;
  logic                  conf_r, conf_nxt;
  logic [TIME_WIDTH-1:0] conf_el_r, conf_el_nxt;
  logic [TIME_WIDTH-1:0] blink_el_r, blink_el_nxt;
  logic                  lit_r, lit_nxt;
  logic [1:0]            led_r, led_nxt;

  logic [TIME_WIDTH-1:0] tap_el_inc, conf_el_inc, blink_el_inc;
  logic [3:0]            tap_cnt_inc;
  logic                  timeout_hit, blink_hit, window_over, in_zone;
  logic                  req, canc;

  // Saturating increments of the elapsed counters.
  assign tap_el_inc   = (&tap_el_r)   ? tap_el_r   : tap_el_r + 1'b1;
  assign conf_el_inc  = (&conf_el_r)  ? conf_el_r  : conf_el_r + 1'b1;
  assign blink_el_inc = (&blink_el_r) ? blink_el_r : blink_el_r + 1'b1;
  assign tap_cnt_inc  = tap_cnt_r + 4'd1;

  assign timeout_hit = CMP_W'(conf_el_inc) >= CMP_W'(cfg.countdown_ms);
  assign blink_hit   = CMP_W'(blink_el_inc) >= CMP_W'(cfg.flash_ms);
  assign window_over = CMP_W'(tap_el_r) > CMP_W'(cfg.tap_window_ms);
  assign in_zone     = (item.zone == cfg.touch_zone);

  always_comb begin
    tap_cnt_nxt  = tap_cnt_r;
    tap_el_nxt   = tap_el_r;
    conf_nxt     = conf_r;
    conf_el_nxt  = conf_el_r;
    blink_el_nxt = blink_el_r;
    lit_nxt      = lit_r;
    led_nxt      = led_r;
    req          = 1'b0;
    canc         = 1'b0;
    if (item.func == FUNC_TICK) begin
      if (tap_cnt_r != 4'd0) begin
        tap_el_nxt = tap_el_inc;
      end
      if (conf_r) begin
        conf_el_nxt  = conf_el_inc;
        blink_el_nxt = blink_el_inc;
        if (timeout_hit) begin
          conf_nxt = 1'b0;
          req      = 1'b1;
          led_nxt  = LED_RED;
        end else if (blink_hit) begin
          blink_el_nxt = '0;
          lit_nxt      = !lit_r;
          led_nxt      = lit_r ? LED_DARK : LED_AMBER;
        end
      end
    end else if (in_zone) begin
      if (conf_r) begin
        conf_nxt = 1'b0;
        led_nxt  = LED_NORMAL;
        canc     = 1'b1;
      end else if (tap_cnt_r == 4'd0 || window_over) begin
        tap_cnt_nxt = 4'd1;
        tap_el_nxt  = '0;
      end else if (tap_cnt_inc >= cfg.taps_needed || tap_cnt_inc == 4'd0) begin
        tap_cnt_nxt  = 4'd0;
        tap_el_nxt   = '0;
        conf_nxt     = 1'b1;
        conf_el_nxt  = '0;
        blink_el_nxt = '0;
      end else begin
        tap_cnt_nxt = tap_cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cnt_r  <= 4'd0;
      tap_el_r   <= '0;
      conf_r     <= 1'b0;
      conf_el_r  <= '0;
      blink_el_r <= '0;
      lit_r      <= 1'b0;
      led_r      <= LED_NORMAL;
    end else if (step) begin
      tap_cnt_r  <= tap_cnt_nxt;
      tap_el_r   <= tap_el_nxt;
      conf_r     <= conf_nxt;
      conf_el_r  <= conf_el_nxt;
      blink_el_r <= blink_el_nxt;
      lit_r      <= lit_nxt;
      led_r      <= led_nxt;
    end
  end

  assign res.led_mode      = led_nxt;
  assign res.confirming    = conf_nxt;
  assign res.reset_request = req;
  assign res.cancelled     = canc;

endmodule

/* src/triple_tap_confirm_sequencer_top.sv */
// Top level of the triple-tap confirmation sequencer: channels, staging and checks.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in_     | input     | in_valid / in_ready    | in_data  (func, zone)
//   out_    | output    | out_valid / out_ready  | out_data (led_mode, confirming,
//           |           |                        |   reset_request, cancelled)
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word is accepted per clock cycle while the output is not stalled; its result
// word is offered after it passes the input register and then the result register.
// The state update for a word is a single pass of counter and compare logic in ttc_core.
// Reset is synchronous and active low; it clears the valid flags, the sequencer state
// and loads the default configuration. cfg_ready is always high.
// A stalled output holds its word; the input register keeps accepting as long as the
// held word is taken in the same cycle or the result register is empty.
`include "triple_tap_confirm_sequencer_top_defines.svh"

module triple_tap_confirm_sequencer_top
  import ttc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  out_t res;

  // Input register: holds the word whose result is computed next.
  logic in_valid_r, in_valid_nxt;
  in_t  in_word_r;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  out_t out_word_r;

  // The staged word moves on when the result register is free or being emptied.
  logic advance;

  assign cfg_ready = 1'b1;

  ttc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  ttc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_word_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // An expiry and a cancel come from different word kinds and never coincide.
  `TTC_ASSERT_NOW(a_req_canc_excl, out_valid, !(out_data.reset_request && out_data.cancelled))
  // An expiry ends the countdown and shows erase red.
  `TTC_ASSERT_NOW(a_req_red, out_valid && out_data.reset_request,
                  !out_data.confirming && out_data.led_mode == LED_RED)
  // A cancel ends the countdown and restores the normal LED.
  `TTC_ASSERT_NOW(a_canc_normal, out_valid && out_data.cancelled,
                  !out_data.confirming && out_data.led_mode == LED_NORMAL)
  // A staged word that advances always lands in the result register.
  `TTC_ASSERT_NEXT(a_advance_lands, advance, out_valid)

endmodule
